[hdl/dll_pkg.sv]
// ----------------------------------------------------------------------------
// dll_pkg
// Shared sizes, types and codes for the linked list manager.
// ----------------------------------------------------------------------------
package dll_pkg;

  localparam int CAPACITY   = 32;
  localparam int VALUE_BITS = 32;

  localparam int SLOT_W = $clog2(CAPACITY);
  localparam int LINK_W = $clog2(CAPACITY + 1);  // holds the null marker too

  localparam int OPCODE_W    = 2;
  localparam int IN_VALUE_W  = 32;
  localparam int STATUS_W    = 2;
  localparam int SLOT_OUT_W  = 5;
  localparam int COUNT_OUT_W = 6;

  typedef logic [SLOT_W-1:0]     slot_t;
  typedef logic [LINK_W-1:0]     link_t;
  typedef logic [VALUE_BITS-1:0] value_t;

  localparam link_t NIL_LINK = LINK_W'(CAPACITY);
  localparam slot_t LAST_STEP = SLOT_W'(CAPACITY - 1);

  typedef enum logic [OPCODE_W-1:0] {
    OP_INS_HEAD = 2'd0,
    OP_INS_TAIL = 2'd1,
    OP_SEARCH   = 2'd2,
    OP_REMOVE   = 2'd3
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE      = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  // occupancy map commands and scan answer
  typedef struct packed {
    logic  scan;
    logic  set;
    logic  clr;
    slot_t slot;
  } alloc_cmd_t;

  typedef struct packed {
    logic  done;
    logic  found;
    slot_t slot;
  } alloc_rsp_t;

endpackage

[hdl/doubly_linked_list_manager.sv]
// ----------------------------------------------------------------------------
// doubly_linked_list_manager
// Bounded doubly linked list of values kept in node memories.
// ----------------------------------------------------------------------------
//  channel   handshake          payload
//  command   start & !busy      opcode, value
//  result    done (one cycle)   status, slot, count
//
//  Insert: a start step, a scan of the occupancy map up to the lowest free
//    slot (at most CAPACITY slots), a link step, and a stitch step when the
//    list is not empty. On a full map the scan runs off the end, no link.
//  Search / remove: a start step, then one read of the node memories per
//    node visited, at most CAPACITY nodes. A search or remove of an empty
//    list answers at once.
//  The result comes in the cycle after the last working cycle; busy is
//    already low then. Reset empties the list at once: no memory clearing.
//  The receiver cannot stall; each result is shown for one cycle.
// ----------------------------------------------------------------------------
module doubly_linked_list_manager (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  output logic                                   busy,
  input  logic [dll_pkg::OPCODE_W-1:0]           opcode,
  input  logic signed [dll_pkg::IN_VALUE_W-1:0]  value,
  output logic                                   done,
  output logic [dll_pkg::STATUS_W-1:0]           status,
  output logic [dll_pkg::SLOT_OUT_W-1:0]         slot,
  output logic [dll_pkg::COUNT_OUT_W-1:0]        count
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SCAN   = 5'b00010,
    S_LINK   = 5'b00100,
    S_STITCH = 5'b01000,
    S_WALK   = 5'b10000
  } state_t;

  state_t             state, state_next;
  dll_pkg::opcode_t   op, op_next;
  dll_pkg::value_t    key, key_next;
  dll_pkg::link_t     head, head_next;
  dll_pkg::link_t     tail, tail_next;
  dll_pkg::link_t     node_count, node_count_next;
  dll_pkg::link_t     cur, cur_next;
  dll_pkg::slot_t     steps, steps_next;
  dll_pkg::slot_t     new_slot, new_slot_next;
  logic               done_next;
  dll_pkg::status_t   status_next;
  logic [dll_pkg::SLOT_OUT_W-1:0]  slot_next;
  logic [dll_pkg::COUNT_OUT_W-1:0] count_next;

  dll_pkg::alloc_cmd_t alloc_cmd;
  dll_pkg::alloc_rsp_t alloc_rsp;

  dll_pkg::slot_t  rd_addr;
  dll_pkg::value_t rd_val;
  dll_pkg::link_t  rd_nx;
  dll_pkg::link_t  rd_pv;

  logic            val_we;
  dll_pkg::value_t val_wd;
  logic            nx_we;
  dll_pkg::slot_t  nx_wa;
  dll_pkg::link_t  nx_wd;
  logic            pv_we;
  dll_pkg::slot_t  pv_wa;
  dll_pkg::link_t  pv_wd;
  dll_pkg::link_t  new_link;

  assign busy     = (state != S_IDLE);
  assign new_link = dll_pkg::LINK_W'(new_slot);

  dll_alloc u_alloc (
    .clk (clk),
    .rst (rst),
    .cmd (alloc_cmd),
    .rsp (alloc_rsp)
  );

  dll_ram #(.WIDTH(dll_pkg::VALUE_BITS), .DEPTH(dll_pkg::CAPACITY)) u_val_ram (
    .clk     (clk),
    .wr_en   (val_we),
    .wr_addr (new_slot),
    .wr_data (val_wd),
    .rd_addr (rd_addr),
    .rd_data (rd_val)
  );

  dll_ram #(.WIDTH(dll_pkg::LINK_W), .DEPTH(dll_pkg::CAPACITY)) u_next_ram (
    .clk     (clk),
    .wr_en   (nx_we),
    .wr_addr (nx_wa),
    .wr_data (nx_wd),
    .rd_addr (rd_addr),
    .rd_data (rd_nx)
  );

  dll_ram #(.WIDTH(dll_pkg::LINK_W), .DEPTH(dll_pkg::CAPACITY)) u_prev_ram (
    .clk     (clk),
    .wr_en   (pv_we),
    .wr_addr (pv_wa),
    .wr_data (pv_wd),
    .rd_addr (rd_addr),
    .rd_data (rd_pv)
  );

  // All writes of an item land before busy drops, so a walk never reads an
  // entry in the cycle it is written: no forwarding needed.
  always_comb begin
    state_next      = state;
    op_next         = op;
    key_next        = key;
    head_next       = head;
    tail_next       = tail;
    node_count_next = node_count;
    cur_next        = cur;
    steps_next      = steps;
    new_slot_next   = new_slot;
    done_next       = 1'b0;
    status_next     = dll_pkg::ST_DONE;
    slot_next       = '0;
    alloc_cmd       = '0;
    rd_addr         = cur[dll_pkg::SLOT_W-1:0];
    val_we          = 1'b0;
    val_wd          = key;
    nx_we           = 1'b0;
    nx_wa           = new_slot;
    nx_wd           = dll_pkg::NIL_LINK;
    pv_we           = 1'b0;
    pv_wa           = new_slot;
    pv_wd           = dll_pkg::NIL_LINK;

    unique case (state)
      S_IDLE: begin
        if (start) begin
          op_next  = dll_pkg::opcode_t'(opcode);
          key_next = dll_pkg::VALUE_BITS'(value);
          if (opcode == dll_pkg::OP_INS_HEAD || opcode == dll_pkg::OP_INS_TAIL) begin
            alloc_cmd.scan = 1'b1;
            state_next     = S_SCAN;
          end else if (head == dll_pkg::NIL_LINK) begin
            done_next   = 1'b1;
            status_next = dll_pkg::ST_NOT_FOUND;
          end else begin
            rd_addr    = head[dll_pkg::SLOT_W-1:0];
            cur_next   = head;
            steps_next = '0;
            state_next = S_WALK;
          end
        end
      end

      S_SCAN: begin
        if (alloc_rsp.done) begin
          if (alloc_rsp.found) begin
            new_slot_next = alloc_rsp.slot;
            state_next    = S_LINK;
          end else begin
            done_next   = 1'b1;
            status_next = dll_pkg::ST_FULL;
            state_next  = S_IDLE;
          end
        end
      end

      S_LINK: begin
        val_we          = 1'b1;
        nx_we           = 1'b1;
        pv_we           = 1'b1;
        alloc_cmd.set   = 1'b1;
        alloc_cmd.slot  = new_slot;
        node_count_next = node_count + dll_pkg::LINK_W'(1);
        if (op == dll_pkg::OP_INS_HEAD) begin
          nx_wd = head;
        end else begin
          pv_wd = tail;
        end
        if ((op == dll_pkg::OP_INS_HEAD && head != dll_pkg::NIL_LINK) ||
            (op != dll_pkg::OP_INS_HEAD && tail != dll_pkg::NIL_LINK)) begin
          state_next = S_STITCH;
        end else begin
          head_next  = new_link;
          tail_next  = new_link;
          done_next  = 1'b1;
          slot_next  = dll_pkg::SLOT_OUT_W'(new_slot);
          state_next = S_IDLE;
        end
      end

      S_STITCH: begin
        // point the old end node at the new one
        if (op == dll_pkg::OP_INS_HEAD) begin
          pv_we     = 1'b1;
          pv_wa     = head[dll_pkg::SLOT_W-1:0];
          pv_wd     = new_link;
          head_next = new_link;
        end else begin
          nx_we     = 1'b1;
          nx_wa     = tail[dll_pkg::SLOT_W-1:0];
          nx_wd     = new_link;
          tail_next = new_link;
        end
        done_next  = 1'b1;
        slot_next  = dll_pkg::SLOT_OUT_W'(new_slot);
        state_next = S_IDLE;
      end

      S_WALK: begin
        if (rd_val == key) begin
          done_next  = 1'b1;
          slot_next  = dll_pkg::SLOT_OUT_W'(cur[dll_pkg::SLOT_W-1:0]);
          state_next = S_IDLE;
          if (op == dll_pkg::OP_REMOVE) begin
            if (cur == head) begin
              head_next = rd_nx;
            end else if (rd_pv != dll_pkg::NIL_LINK) begin
              nx_we = 1'b1;
              nx_wa = rd_pv[dll_pkg::SLOT_W-1:0];
              nx_wd = rd_nx;
            end
            if (cur == tail) begin
              tail_next = rd_pv;
            end else if (rd_nx != dll_pkg::NIL_LINK) begin
              pv_we = 1'b1;
              pv_wa = rd_nx[dll_pkg::SLOT_W-1:0];
              pv_wd = rd_pv;
            end
            alloc_cmd.clr  = 1'b1;
            alloc_cmd.slot = cur[dll_pkg::SLOT_W-1:0];
            if (node_count != '0) begin
              node_count_next = node_count - dll_pkg::LINK_W'(1);
            end
          end
        end else if (rd_nx == dll_pkg::NIL_LINK || steps == dll_pkg::LAST_STEP) begin
          done_next   = 1'b1;
          status_next = dll_pkg::ST_NOT_FOUND;
          state_next  = S_IDLE;
        end else begin
          // follow the link straight from the read data
          rd_addr    = rd_nx[dll_pkg::SLOT_W-1:0];
          cur_next   = rd_nx;
          steps_next = steps + dll_pkg::SLOT_W'(1);
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    count_next = dll_pkg::COUNT_OUT_W'(node_count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      head       <= dll_pkg::NIL_LINK;
      tail       <= dll_pkg::NIL_LINK;
      node_count <= '0;
      done       <= 1'b0;
    end else begin
      state      <= state_next;
      head       <= head_next;
      tail       <= tail_next;
      node_count <= node_count_next;
      done       <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    op       <= op_next;
    key      <= key_next;
    cur      <= cur_next;
    steps    <= steps_next;
    new_slot <= new_slot_next;
    status   <= status_next;
    slot     <= slot_next;
    count    <= count_next;
  end

endmodule

[hdl/dll_ram.sv]
// ----------------------------------------------------------------------------
// dll_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module dll_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[hdl/dll_alloc.sv]
// ----------------------------------------------------------------------------
// dll_alloc
// Slot occupancy map with a one-slot-per-cycle scan for the lowest free slot.
// ----------------------------------------------------------------------------
module dll_alloc (
  input  logic                clk,
  input  logic                rst,
  input  dll_pkg::alloc_cmd_t cmd,
  output dll_pkg::alloc_rsp_t rsp
);

  logic [dll_pkg::CAPACITY-1:0] used;
  logic                         scanning;
  dll_pkg::link_t               idx;
  logic                         at_end;
  logic                         free_hit;

  assign at_end   = (idx == dll_pkg::NIL_LINK);
  assign free_hit = !at_end && !used[idx[dll_pkg::SLOT_W-1:0]];

  assign rsp.done  = scanning && (at_end || free_hit);
  assign rsp.found = free_hit;
  assign rsp.slot  = idx[dll_pkg::SLOT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      used     <= '0;
      scanning <= 1'b0;
    end else begin
      if (cmd.scan) begin
        scanning <= 1'b1;
      end else if (rsp.done) begin
        scanning <= 1'b0;
      end
      if (cmd.set) begin
        used[cmd.slot] <= 1'b1;
      end
      if (cmd.clr) begin
        used[cmd.slot] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      idx <= '0;
    end else if (scanning && !rsp.done) begin
      idx <= idx + dll_pkg::LINK_W'(1);
    end
  end

endmodule

[hdl/dll_checker.sv]
// ----------------------------------------------------------------------------
// dll_checker
// Port-level checks on the linked list manager, bound to the top level.
// ----------------------------------------------------------------------------
module dll_checker (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  start,
  input logic                                  busy,
  input logic                                  done,
  input logic [dll_pkg::STATUS_W-1:0]          status,
  input logic [dll_pkg::SLOT_OUT_W-1:0]        slot,
  input logic [dll_pkg::COUNT_OUT_W-1:0]       count
);

  // a failed beat carries no slot
  a_fail_slot_zero: assert property (@(posedge clk) disable iff (rst)
    done && status != dll_pkg::ST_DONE |-> slot == '0)
    else $error("nonzero slot on failed result");

  // an insert is only dropped when every slot is taken
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    done && status == dll_pkg::ST_FULL |->
      count == dll_pkg::COUNT_OUT_W'(dll_pkg::CAPACITY))
    else $error("full reported below capacity");

  // an accepted command keeps the block busy or answers next cycle
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy || done)
    else $error("accepted command neither busy nor answered");

  // no result without work behind it
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy || start))
    else $error("result without a command");

endmodule

bind doubly_linked_list_manager dll_checker u_dll_checker (.*);
